// File: hw/rtl/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the decoder.
package u8sd_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CP_W   = 21;
   localparam int unsigned WORD_W = 32;

   localparam logic [WORD_W-1:0] MARKER_RESET = 32'h0000_FFFD;

   // Sequence length codes: number of following bytes
   localparam logic [1:0] SEQ_ONE   = 2'd0;
   localparam logic [1:0] SEQ_TWO   = 2'd1;
   localparam logic [1:0] SEQ_THREE = 2'd2;
   localparam logic [1:0] SEQ_FOUR  = 2'd3;

   localparam logic [CP_W-1:0] MIN_TWO   = 21'h00080;
   localparam logic [CP_W-1:0] MIN_THREE = 21'h00800;
   localparam logic [CP_W-1:0] MIN_FOUR  = 21'h10000;
   localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;

   // One gathered code point, handed from the front to the back
   typedef struct packed {
      logic            err;      // malformed lead or truncated string
      logic [1:0]      seq_len;  // length code, checked for overlong/range
      logic [CP_W-1:0] value;
      logic            is_last;
   } item_type;

endpackage

// File: hw/rtl/u8sd_front.sv
// Front of the UTF-8 stream decoder: classifies lead bytes and gathers
// following bytes into a code point. Depends on u8sd_pkg.
module u8sd_front
   import u8sd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       q_full,
   output logic       push,
   output item_type   push_item
);

   logic [1:0]      bytes_left_ff, bytes_left_in;
   logic [1:0]      seq_length_ff, seq_length_in;
   logic [CP_W-1:0] partial_ff, partial_in;

   logic            accept;
   logic [CP_W-1:0] shifted;
   logic [1:0]      left_dec;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign shifted   = {partial_ff[CP_W-7:0], req_data_byte[5:0]};
   assign left_dec  = bytes_left_ff - 2'd1;

   always_comb begin
      bytes_left_in     = bytes_left_ff;
      seq_length_in     = seq_length_ff;
      partial_in        = partial_ff;
      push              = 1'b0;
      push_item.err     = 1'b0;
      push_item.seq_len = SEQ_ONE;
      push_item.value   = {{(CP_W-8){1'b0}}, req_data_byte};
      push_item.is_last = req_last_byte;
      if (accept) begin
         if (bytes_left_ff == 2'd0) begin
            if (!req_data_byte[7]) begin
               push = 1'b1;
            end else if (req_data_byte[7:5] == 3'b110 && !req_last_byte) begin
               seq_length_in = SEQ_TWO;
               bytes_left_in = SEQ_TWO;
               partial_in    = {{(CP_W-5){1'b0}}, req_data_byte[4:0]};
            end else if (req_data_byte[7:4] == 4'b1110 && !req_last_byte) begin
               seq_length_in = SEQ_THREE;
               bytes_left_in = SEQ_THREE;
               partial_in    = {{(CP_W-4){1'b0}}, req_data_byte[3:0]};
            end else if (req_data_byte[7:3] == 5'b11110 && !req_last_byte) begin
               seq_length_in = SEQ_FOUR;
               bytes_left_in = SEQ_FOUR;
               partial_in    = {{(CP_W-3){1'b0}}, req_data_byte[2:0]};
            end else begin
               // bad lead, or a valid lead that is also the string's last byte
               push          = 1'b1;
               push_item.err = 1'b1;
            end
         end else if (left_dec == 2'd0) begin
            push              = 1'b1;
            push_item.seq_len = seq_length_ff;
            push_item.value   = shifted;
            bytes_left_in     = 2'd0;
            seq_length_in     = SEQ_ONE;
            partial_in        = '0;
         end else if (req_last_byte) begin
            push          = 1'b1;
            push_item.err = 1'b1;
            bytes_left_in = 2'd0;
            seq_length_in = SEQ_ONE;
            partial_in    = '0;
         end else begin
            bytes_left_in = left_dec;
            partial_in    = shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 2'd0;
         seq_length_ff <= SEQ_ONE;
         partial_ff    <= '0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         seq_length_ff <= seq_length_in;
         partial_ff    <= partial_in;
      end
   end

endmodule

// File: hw/rtl/u8sd_queue.sv
// Short queue between the decoder front and back.
// Depends on u8sd_pkg for the item type and depth.
module u8sd_queue
   import u8sd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     q_valid,
   output item_type q_item
);

   item_type                 slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = slots_ff[rd_ptr_ff];

   function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
      logic [QUEUE_PTR_W-1:0] r;
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/u8sd_back.sv
// Back of the UTF-8 stream decoder: range checks, marker substitution,
// the marker register and the result register. Depends on u8sd_pkg.
module u8sd_back
   import u8sd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [WORD_W-1:0] csr_wdata,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_code_point,
   output logic              rsp_invalid,
   output logic              rsp_string_end
);

   logic [WORD_W-1:0] marker_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] code_point_ff, code_point_in;
   logic              invalid_ff, invalid_in;
   logic              string_end_ff, string_end_in;
   logic              bad;

   assign csr_ready = 1'b1;
   assign pop       = q_valid && (!rsp_valid_ff || rsp_ready);

   // overlong or out-of-range check on a completed sequence, combined with the front's error flag
   always_comb begin
      case (q_item.seq_len)
         SEQ_ONE:   bad = 1'b0;
         SEQ_TWO:   bad = (q_item.value < MIN_TWO);
         SEQ_THREE: bad = (q_item.value < MIN_THREE);
         SEQ_FOUR:  bad = (q_item.value < MIN_FOUR) || (q_item.value > MAX_CP);
         default:   bad = 1'b1;
      endcase
      bad = bad || q_item.err;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      code_point_in = code_point_ff;
      invalid_in    = invalid_ff;
      string_end_in = string_end_ff;
      if (pop) begin
         rsp_valid_in  = 1'b1;
         code_point_in = bad ? marker_ff : {{(WORD_W-CP_W){1'b0}}, q_item.value};
         invalid_in    = bad;
         string_end_in = q_item.is_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff    <= MARKER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            marker_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_point_ff <= code_point_in;
      invalid_ff    <= invalid_in;
      string_end_ff <= string_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = code_point_ff;
   assign rsp_invalid    = invalid_ff;
   assign rsp_string_end = string_end_ff;

endmodule

// File: hw/rtl/utf8_stream_decoder_top.sv
// UTF-8 stream decoder, top level. Depends on u8sd_pkg, u8sd_front,
// u8sd_queue and u8sd_back.
// Throughput: one byte per cycle; input stalls only while both queue slots hold items.
// A code point's queue item is written at the edge that accepts its completing byte;
// the back pops it into the result register once that register is empty or being taken.
// Reset (synchronous, active high) empties the queue, drops any pending
// sequence and loads the invalid marker with 0xFFFD.
module utf8_stream_decoder_top
   import u8sd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [WORD_W-1:0] csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_code_point,
   output logic              rsp_invalid,
   output logic              rsp_string_end
);

   logic     push;
   item_type push_item;
   logic     q_full;
   logic     pop;
   logic     q_valid;
   item_type q_item;

   u8sd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .push          (push),
      .push_item     (push_item)
   );

   u8sd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   u8sd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_invalid    (rsp_invalid),
      .rsp_string_end (rsp_string_end)
   );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for utf8_stream_decoder_top: predicts each decoded code point
// in step with the byte stream and compares every result beat. Depends on u8sd_pkg.
module testbench;
   import u8sd_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200_000;
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [WORD_W-1:0] code_point;
      logic              invalid;
      logic              string_end;
   } cp_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [WORD_W-1:0] csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_data_byte = '0;
   logic              req_last_byte = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [WORD_W-1:0] rsp_code_point;
   logic              rsp_invalid;
   logic              rsp_string_end;

   // decoder state as predicted
   logic [1:0]        pred_left = 2'd0;
   logic [1:0]        pred_len = SEQ_ONE;
   logic [CP_W-1:0]   pred_acc = '0;
   logic [WORD_W-1:0] pred_marker = MARKER_RESET;

   cp_result_type expected_cps[$];
   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned cycle_count = 0;
   logic        quiet = 1'b0;

   utf8_stream_decoder_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_invalid    (rsp_invalid),
      .rsp_string_end (rsp_string_end)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("utf8_stream_decoder_top: mismatch");
         $finish;
      end
   end

   task automatic push_result(input logic [WORD_W-1:0] cp, input logic bad, input logic fin);
      cp_result_type r;
      r.code_point = cp;
      r.invalid    = bad;
      r.string_end = fin;
      expected_cps.insert(expected_cps.size(), r);
   endtask

   // Advances the predicted decoder by one accepted byte.
   task automatic predict_code_point(input logic [7:0] b, input logic fin);
      logic bad;
      if (pred_left == 2'd0) begin
         if (b[7] == 1'b0) begin
            push_result({25'd0, b[6:0]}, 1'b0, fin);
         end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            if (b[7:5] == 3'b110) begin
               pred_len = SEQ_TWO;
               pred_acc = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
               pred_len = SEQ_THREE;
               pred_acc = {17'd0, b[3:0]};
            end else begin
               pred_len = SEQ_FOUR;
               pred_acc = {18'd0, b[2:0]};
            end
            if (fin) begin
               // lead byte that ends the string
               pred_len = SEQ_ONE;
               pred_acc = '0;
               push_result(pred_marker, 1'b1, 1'b1);
            end else begin
               pred_left = pred_len;
            end
         end else begin
            push_result(pred_marker, 1'b1, fin);
         end
      end else begin
         // prefix of following bytes is not checked
         pred_acc  = {pred_acc[CP_W-7:0], b[5:0]};
         pred_left = pred_left - 2'd1;
         if (pred_left == 2'd0) begin
            case (pred_len)
               SEQ_TWO:   bad = pred_acc < MIN_TWO;
               SEQ_THREE: bad = pred_acc < MIN_THREE;
               default:   bad = pred_acc < MIN_FOUR || pred_acc > MAX_CP;
            endcase
            push_result(bad ? pred_marker : {11'd0, pred_acc}, bad, fin);
            pred_len = SEQ_ONE;
            pred_acc = '0;
         end else if (fin) begin
            pred_left = 2'd0;
            pred_len  = SEQ_ONE;
            pred_acc  = '0;
            push_result(pred_marker, 1'b1, 1'b1);
         end
      end
   endtask

   always @(posedge clock) begin
      cp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cps.size() == 0) begin
            $display("%0t: unexpected result, expected none, got cp %h invalid %b end %b",
                     $time, rsp_code_point, rsp_invalid, rsp_string_end);
            error_count++;
         end else begin
            want = expected_cps.pop_front();
            if (rsp_code_point !== want.code_point) begin
               $display("%0t: code_point expected %h, got %h",
                        $time, want.code_point, rsp_code_point);
               error_count++;
            end
            if (rsp_invalid !== want.invalid) begin
               $display("%0t: invalid expected %b, got %b", $time, want.invalid, rsp_invalid);
               error_count++;
            end
            if (rsp_string_end !== want.string_end) begin
               $display("%0t: string_end expected %b, got %b",
                        $time, want.string_end, rsp_string_end);
               error_count++;
            end
         end
      end
   end

   // result side back-pressure in bursts
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Called at a falling edge; returns at a falling edge with valid still high.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      do @(posedge clock); while (!req_ready);
      predict_code_point(b, fin);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Encodes cp in nbytes bytes, may mangle following-byte prefixes, sends the first keep of them.
   task automatic send_char(input logic [20:0] cp, input int nbytes, input int keep,
                            input logic fin, input logic mangle);
      logic [7:0] enc [4];
      int i;
      enc[1] = {2'b10, cp[5:0]};
      enc[2] = {2'b10, cp[5:0]};
      enc[3] = {2'b10, cp[5:0]};
      case (nbytes)
         1: enc[0] = {1'b0, cp[6:0]};
         2: enc[0] = {3'b110, cp[10:6]};
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
         end
      endcase
      for (i = 1; i < nbytes; i++) begin
         if (mangle && $urandom_range(0, 1) == 1) enc[i][7:6] = 2'($urandom_range(0, 3));
      end
      for (i = 0; i < keep; i++) begin
         send_byte(enc[i], fin && (i == keep - 1));
      end
   endtask

   // Drops valid, lets every expected beat arrive, then lets the pipe settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_cps.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_marker(input logic [WORD_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      pred_marker = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_basic_forms();
      send_char(21'h0, 1, 1, 1'b0, 1'b0);
      send_char(21'h7F, 1, 1, 1'b1, 1'b0);
      send_char(21'h80, 2, 2, 1'b0, 1'b0);
      send_char(21'h7F, 2, 2, 1'b0, 1'b0);       // overlong
      send_char(21'h7FF, 3, 3, 1'b0, 1'b0);      // overlong
      send_char(21'hD800, 3, 3, 1'b0, 1'b0);     // surrogate passes
      send_char(21'h10FFFF, 4, 4, 1'b1, 1'b0);
      send_char(21'h110000, 4, 4, 1'b0, 1'b0);   // above range
      send_char(21'hFFFF, 4, 4, 1'b1, 1'b0);     // overlong
   endtask

   task automatic test_error_leads();
      send_byte(8'h80, 1'b0);                    // stray continuation
      send_byte(8'hFF, 1'b0);
      send_byte(8'hC3, 1'b1);                    // lead that ends the string
      send_char(21'h10000, 4, 3, 1'b1, 1'b0);    // string cut mid-sequence
      send_byte(8'hC3, 1'b0);
      send_byte(8'h00, 1'b1);                    // following byte without 10 prefix
   endtask

   task automatic test_marker_values();
      write_marker('0);
      send_byte(8'hFF, 1'b0);
      write_marker('1);
      send_byte(8'hC2, 1'b1);
      send_byte(8'h41, 1'b0);
      write_marker(32'h41);                      // good 'A' equals the marker
      send_byte(8'h41, 1'b0);
      send_byte(8'h80, 1'b1);
      write_marker($urandom());
      send_char(21'h20AC, 3, 2, 1'b1, 1'b0);
   endtask

   task automatic send_random_string();
      int unsigned n_chars, k, kind, nb;
      logic fin;
      n_chars = $urandom_range(1, 8);
      for (k = 0; k < n_chars; k++) begin
         fin  = (k == n_chars - 1);
         kind = $urandom_range(0, 19);
         case (kind)
            0, 1, 2, 3: send_char(21'($urandom_range(0, 'h7F)), 1, 1, fin, 1'b0);
            4, 5, 6:    send_char(21'($urandom_range('h80, 'h7FF)), 2, 2, fin, 1'b0);
            7, 8, 9:    send_char(21'($urandom_range('h800, 'hFFFF)), 3, 3, fin, 1'b0);
            10, 11, 12: send_char(21'($urandom_range('h10000, 'h10FFFF)), 4, 4, fin, 1'b0);
            13: begin
               nb = $urandom_range(2, 4);
               send_char(21'($urandom_range(0, nb == 2 ? 'h7F : nb == 3 ? 'h7FF : 'hFFFF)),
                         nb, nb, fin, 1'b0);
            end
            14: send_char(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4, fin, 1'b0);
            15: begin
               nb = $urandom_range(2, 4);
               send_char(21'($urandom_range(0, 'h1FFFFF)), nb, nb, fin, 1'b1);
            end
            16: begin
               // truncation closes the string
               nb = $urandom_range(2, 4);
               send_char(21'($urandom_range(0, 'h1FFFFF)), nb, $urandom_range(1, nb - 1),
                         1'b1, 1'b0);
               k = n_chars;
            end
            default: send_byte(8'($urandom_range(0, 255)), fin);
         endcase
      end
   endtask

   task automatic test_random_strings();
      int unsigned chunk, goal;
      goal = bytes_sent;
      for (chunk = 0; chunk < 5; chunk++) begin
         goal += 100;
         if (chunk == 4) quiet = 1'b1;
         while (bytes_sent < goal) begin
            send_random_string();
            if (!quiet && $urandom_range(0, 24) == 0) wait_idle();
         end
         case (chunk)
            0: write_marker('0);
            1: write_marker($urandom());
            2: write_marker('1);
            3: write_marker(MARKER_RESET);
            default: ;
         endcase
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_forms();
      test_error_leads();
      test_marker_values();
      test_random_strings();
      wait_idle();
      if (error_count == 0) begin
         $display("utf8_stream_decoder_top: match");
      end else begin
         $display("utf8_stream_decoder_top: mismatch");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_front.sv
hw/rtl/u8sd_queue.sv
hw/rtl/u8sd_back.sv
hw/rtl/utf8_stream_decoder_top.sv
verif/testbench.sv
